[sv/mse_pkg.sv]
// Shared types and constants for the multi-stack engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

   localparam int NUM_STACKS  = 8;
   localparam int STACK_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;

   localparam int MEM_DEPTH  = NUM_STACKS * STACK_DEPTH;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int DEPTH_W    = $clog2(STACK_DEPTH);
   localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
   localparam int LIM_W      = 5;
   localparam int SIU_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIU_W-1:0] SIU_RESET = 4'd8;
   localparam logic REG_STACKS_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      FN_PUSH    = 2'd0,
      FN_POP     = 2'd1,
      FN_DISPLAY = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_POP_RD,
      S_DISP
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         stack_sel;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       push_wr;
      logic       pop;
      logic       disp_load;
      logic       disp_step;
      logic       emit;
      logic       emit_data;
      logic       emit_last;
      status_type emit_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       invalid;
      logic       empty;
      logic       full;
      logic       idx_zero;
   } sts_type;

endpackage
`default_nettype wire

[sv/mse_controller.sv]
// Sequencer for the multi-stack engine: decodes the captured item and
// drives the datapath commands. Depends on mse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mse_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mse_pkg::sts_type sts,
   output mse_pkg::cmd_type cmd
);
   import mse_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (!sts.invalid && !sts.empty) begin
               if (sts.func == FN_POP) begin
                  state_in = S_POP_RD;
               end else if (sts.func == FN_DISPLAY) begin
                  state_in = S_DISP;
               end
            end
         end
         S_POP_RD: begin
            state_in = S_IDLE;
         end
         S_DISP: begin
            if (sts.idx_zero) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.emit_status = ST_OK;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_DECODE: begin
            cmd.emit_last = 1'b1;
            priority if (sts.func != FN_PUSH && sts.func != FN_POP
                         && sts.func != FN_DISPLAY) begin
               cmd.emit = 1'b0;
            end else if (sts.invalid) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_INVALID;
            end else if (sts.func == FN_PUSH) begin
               cmd.emit        = 1'b1;
               cmd.push_wr     = !sts.full;
               cmd.emit_status = sts.full ? ST_FULL : ST_OK;
            end else if (sts.empty) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_EMPTY;
            end else if (sts.func == FN_POP) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.disp_load = 1'b1;
            end
         end
         S_POP_RD: begin
            cmd.emit      = 1'b1;
            cmd.emit_data = 1'b1;
            cmd.emit_last = 1'b1;
         end
         S_DISP: begin
            cmd.emit      = 1'b1;
            cmd.emit_data = 1'b1;
            cmd.emit_last = sts.idx_zero;
            cmd.disp_step = !sts.idx_zero;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

   a_push_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> (!sts.full && !sts.invalid))
      else $error("push write on full or invalid stack");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.disp_step |-> !sts.idx_zero)
      else $error("display stepped below bottom of stack");

   a_data_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_data) |-> (state_ff == S_POP_RD || state_ff == S_DISP))
      else $error("data result outside read states");

endmodule
`default_nettype wire

[sv/mse_datapath.sv]
// Datapath for the multi-stack engine: item capture, fill counters, shared
// stack memory, result register and the stacks_in_use CSR. Depends on mse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mse_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mse_pkg::req_type                 req_data,
   input  mse_pkg::cmd_type                 cmd,
   output mse_pkg::sts_type                 sts,
   output logic                             rsp_valid,
   output mse_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mse_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mse_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mse_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import mse_pkg::*;

   req_type                req_ff;
   req_type                req_in;
   logic [SIU_W-1:0]       siu_ff;
   logic [SIU_W-1:0]       siu_in;
   logic [FILL_W-1:0]      fill_ff [NUM_STACKS];
   logic [FILL_W-1:0]      fill_in [NUM_STACKS];
   logic [DEPTH_W-1:0]     idx_ff;
   logic [DEPTH_W-1:0]     idx_in;
   logic [DATA_WIDTH-1:0]  rdata_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [DATA_WIDTH-1:0]  stack_mem_ff [MEM_DEPTH];

   logic [LIM_W-1:0]       limit;
   logic [FILL_W-1:0]      fill_rd;
   logic [FILL_W-1:0]      fill_m1;
   logic [ADDR_W-1:0]      base;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [DEPTH_W-1:0]     rd_idx;
   logic                   csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_STACKS_IN_USE) ?
                   CSR_DATA_W'(siu_ff) : '0;

   always_comb begin
      limit = (LIM_W'(siu_ff) < LIM_W'(NUM_STACKS)) ? LIM_W'(siu_ff) : LIM_W'(NUM_STACKS);
      fill_rd = fill_ff[req_ff.stack_sel];
      fill_m1 = fill_rd - 1'b1;
      base    = ADDR_W'(req_ff.stack_sel) * ADDR_W'(STACK_DEPTH);
      wr_addr = base + ADDR_W'(fill_rd);
      rd_idx  = cmd.disp_step ? (idx_ff - 1'b1) : DEPTH_W'(fill_m1);
      rd_addr = base + ADDR_W'(rd_idx);

      sts.func     = req_ff.func;
      sts.invalid  = (LIM_W'(req_ff.stack_sel) >= limit);
      sts.empty    = (fill_rd == '0);
      sts.full     = (fill_rd >= FILL_W'(STACK_DEPTH));
      sts.idx_zero = (idx_ff == '0);

      req_in = cmd.capture ? req_data : req_ff;
      siu_in = (csr_wr && paddr[CSR_ADDR_W-1] == REG_STACKS_IN_USE) ?
               pwdata[SIU_W-1:0] : siu_ff;

      idx_in = idx_ff;
      if (cmd.disp_load || cmd.disp_step) begin
         idx_in = rd_idx;
      end

      for (int s = 0; s < NUM_STACKS; s++) begin
         fill_in[s] = fill_ff[s];
      end
      if (cmd.push_wr) begin
         fill_in[req_ff.stack_sel] = fill_rd + 1'b1;
      end else if (cmd.pop) begin
         fill_in[req_ff.stack_sel] = fill_m1;
      end

      rsp_in.result_value = cmd.emit_data ? $signed(32'(rdata_ff)) : '0;
      rsp_in.status       = cmd.emit_status;
      rsp_in.last         = cmd.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff       <= SIU_RESET;
         rsp_valid_ff <= 1'b0;
         req_ff       <= '0;
         for (int s = 0; s < NUM_STACKS; s++) begin
            fill_ff[s] <= '0;
         end
      end else begin
         siu_ff       <= siu_in;
         rsp_valid_ff <= cmd.emit;
         req_ff       <= req_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         stack_mem_ff[wr_addr] <= DATA_WIDTH'($unsigned(req_ff.push_value));
      end
      rdata_ff <= stack_mem_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |->
      (rsp_ff.result_value == '0 && rsp_ff.last))
      else $error("error result carries data or is not last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_rd <= FILL_W'(STACK_DEPTH))
      else $error("fill count beyond stack depth");

   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> (fill_ff[$past(req_ff.stack_sel)] == $past(fill_m1)))
      else $error("pop did not decrement fill count");

endmodule
`default_nettype wire

[sv/multi_stack_engine.sv]
// Multi-stack engine top level: NUM_STACKS LIFO stacks in one shared memory.
// Results are registered: push and error results are emitted in the decode state, pop
// and display data in the read states from the registered memory read. New items are
// taken only while busy is low. Display runs top down, one word per cycle from the read port.
// Synchronous reset empties all stacks at once and sets stacks_in_use to 8.
// Results cannot be stalled. Depends on mse_pkg, mse_controller, mse_datapath.
`timescale 1ns / 1ps
`default_nettype none
module multi_stack_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mse_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output mse_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mse_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mse_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mse_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import mse_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mse_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mse_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

endmodule
`default_nettype wire
